[src/bfu_pkg.sv]
// shared constants for the packed field unpacker
package bfu_pkg;
  localparam int unsigned BUF_BITS   = 256;
  localparam int unsigned FIELD_BITS = 192;
  localparam int unsigned FILL_BITS  = 9;
  localparam int unsigned COEFF_BITS = 64;
  localparam int unsigned IDX_BITS   = 2;

  typedef enum logic [IDX_BITS-1:0] {
    REG_FIELD_WIDTH = 2'd0,
    REG_MODULUS     = 2'd1,
    REG_COEFF_COUNT = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;
endpackage

[src/bitfield_unpack_mod_reduce_top.sv]
// top level of the packed field unpacker with modular reduction
//
// Words of a little-endian packed bit string enter on the limb request channel
// (in_valid / in_stall), least significant word first. The block cuts the
// string into fields of field_width bits, reduces each modulo modulus and
// sends it on the coeff/last channel (out_valid / out_stall); last marks the
// final coefficient of a run of coeff_count coefficients, after which the bit
// buffer clears and the rest of that word is dropped.
// A two-entry word queue sits in front of the engine, so words are taken
// while the engine works or a result waits.
// Each word is appended to the bit buffer in the S_LOAD state. Each field is
// loaded in S_LOAD, then reduced bit-serially in S_REDUCE, one step per field
// bit (skipped when modulus is zero), then moved into the output register in
// S_HOLD. The one-bit-a-cycle reduction loop sets the rate.
// A stalled result holds in the output register; the engine waits behind it
// and the queue fills, then in_stall rises.
// Reset (rst, synchronous) sets field_width 64, modulus 1, coeff_count 1 and
// empties buffer and queue. Any register write does the same to the run state.
module bitfield_unpack_mod_reduce_top #(
  parameter int unsigned WORD_BITS  = 64,
  parameter int unsigned COUNT_BITS = 21
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bfu_pkg::IDX_BITS-1:0]   wr_index,
  input  logic [bfu_pkg::COEFF_BITS-1:0] wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [WORD_BITS-1:0]           limb,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bfu_pkg::COEFF_BITS-1:0] coeff,
  output logic                           last
);
  logic [7:0]                     field_width;
  logic [bfu_pkg::COEFF_BITS-1:0] modulus;
  logic [COUNT_BITS-1:0]          coeff_count;
  logic [7:0]                     width_eff;
  logic [COUNT_BITS-1:0]          count_eff;
  logic                           q_valid;
  logic [WORD_BITS-1:0]           q_data;
  logic                           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= 8'd64;
      modulus     <= 64'd1;
      coeff_count <= COUNT_BITS'(1);
    end else if (wr_en) begin
      case (wr_index)
        bfu_pkg::REG_FIELD_WIDTH: field_width <= wr_data[7:0];
        bfu_pkg::REG_MODULUS:     modulus     <= wr_data;
        bfu_pkg::REG_COEFF_COUNT: coeff_count <= wr_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (field_width == 8'd0) begin
      width_eff = 8'd1;
    end else if (field_width > 8'(3 * WORD_BITS)) begin
      width_eff = 8'(3 * WORD_BITS);
    end else begin
      width_eff = field_width;
    end
  end

  assign count_eff = (coeff_count == '0) ? COUNT_BITS'(1) : coeff_count;

  bfu_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .flush    (wr_en),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .limb     (limb),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  bfu_back #(.WORD_BITS(WORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .clr       (wr_en),
    .width_eff (width_eff),
    .count_eff (count_eff),
    .modulus   (modulus),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .coeff     (coeff),
    .last      (last)
  );

  a_write_aborts: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !out_valid) else $error("result present after register write");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && modulus != '0 |-> coeff < modulus) else $error("coefficient not reduced");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");
endmodule

[src/bfu_front.sv]
// input word queue between the request channel and the unpacking engine
module bfu_front #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 flush,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] limb,
  output logic                 q_valid,
  output logic [WORD_BITS-1:0] q_data,
  input  logic                 q_pop
);
  logic [WORD_BITS-1:0] entries [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall && !flush;
  assign q_valid  = (count != 2'd0);
  assign q_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= limb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

[src/bfu_back.sv]
// bit buffer, field extraction and bit-serial modular reduction
module bfu_back #(
  parameter int unsigned WORD_BITS  = 64,
  parameter int unsigned COUNT_BITS = 21
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic [7:0]                    width_eff,
  input  logic [COUNT_BITS-1:0]         count_eff,
  input  logic [bfu_pkg::COEFF_BITS-1:0] modulus,
  input  logic                          q_valid,
  input  logic [WORD_BITS-1:0]          q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bfu_pkg::COEFF_BITS-1:0] coeff,
  output logic                          last
);
  typedef enum logic [1:0] {S_LOAD, S_REDUCE, S_HOLD} state_t;

  state_t                             state;
  logic [bfu_pkg::BUF_BITS-1:0]       bit_buffer;
  logic [bfu_pkg::FILL_BITS-1:0]      buffer_fill;
  logic [COUNT_BITS-1:0]              emitted_count;
  logic [bfu_pkg::FIELD_BITS-1:0]     field;
  logic [bfu_pkg::COEFF_BITS-1:0]     rem;
  logic [7:0]                         steps;
  logic                               fin;

  logic                               have_field;
  logic                               fin_next;
  logic [COUNT_BITS:0]                count_inc;
  logic [bfu_pkg::COEFF_BITS-1:0]     low_mask;
  logic [bfu_pkg::COEFF_BITS-1:0]     low_field;
  logic [bfu_pkg::BUF_BITS-1:0]       limb_shift;
  logic [bfu_pkg::COEFF_BITS-1:0]     rem_shift;
  logic [bfu_pkg::COEFF_BITS-1:0]     rem_next;
  logic [7:0]                         align;

  assign have_field = (buffer_fill >= {1'b0, width_eff});
  assign count_inc  = {1'b0, emitted_count} + 1'b1;
  assign fin_next   = (count_inc >= {1'b0, count_eff});
  assign q_pop      = (state == S_LOAD) && !have_field && q_valid && !clr;
  assign low_mask   = (width_eff >= 8'd64) ? '1 : ((64'd1 << width_eff[5:0]) - 64'd1);
  assign low_field  = bit_buffer[bfu_pkg::COEFF_BITS-1:0] & low_mask;
  assign limb_shift = {{(bfu_pkg::BUF_BITS-WORD_BITS){1'b0}}, q_data} << buffer_fill[7:0];
  assign align      = 8'(bfu_pkg::FIELD_BITS) - width_eff;

  // one restoring step: shift in the next field bit, subtract on overflow or compare
  always_comb begin
    rem_shift = {rem[bfu_pkg::COEFF_BITS-2:0], field[bfu_pkg::FIELD_BITS-1]};
    if (rem[bfu_pkg::COEFF_BITS-1] || rem_shift >= modulus) begin
      rem_next = rem_shift - modulus;
    end else begin
      rem_next = rem_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      state         <= S_LOAD;
      bit_buffer    <= '0;
      buffer_fill   <= '0;
      emitted_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (have_field) begin
            // left-align the field so the msb comes out first
            field <= bit_buffer[bfu_pkg::FIELD_BITS-1:0] << align;
            rem   <= (modulus == '0) ? low_field : '0;
            steps <= width_eff;
            fin   <= fin_next;
            if (fin_next) begin
              bit_buffer    <= '0;
              buffer_fill   <= '0;
              emitted_count <= '0;
            end else begin
              bit_buffer    <= bit_buffer >> width_eff;
              buffer_fill   <= buffer_fill - {1'b0, width_eff};
              emitted_count <= count_inc[COUNT_BITS-1:0];
            end
            state <= (modulus == '0) ? S_HOLD : S_REDUCE;
          end else if (q_valid) begin
            bit_buffer  <= bit_buffer | limb_shift;
            buffer_fill <= buffer_fill + bfu_pkg::FILL_BITS'(WORD_BITS);
          end
        end
        S_REDUCE: begin
          rem   <= rem_next;
          field <= field << 1;
          steps <= steps - 8'd1;
          if (steps == 8'd1) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            coeff     <= rem;
            last      <= fin;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end
endmodule
